>>> design/power_legacy_alu_unit_macros.svh
// Assertion macros for the legacy POWER integer unit checker.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef POWER_LEGACY_ALU_UNIT_MACROS_SVH
`define POWER_LEGACY_ALU_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PLA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pla checker: property failed");

// Next-cycle implication, disabled while reset is asserted
`define PLA_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pla checker: property failed");

`endif

>>> design/pla_pkg.sv
// Shared constants and helpers for the legacy POWER integer unit.
// No dependencies; used by the top level.
package pla_pkg;

  localparam int DATA_W  = 32;
  localparam int CLS_W   = 5;
  localparam int LINE_W  = 11;
  localparam int OP_W    = 3;
  localparam int CR_W    = 4;
  localparam int CNT_W   = $clog2(DATA_W);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ABS  = 3'd0;
  localparam logic [OP_W-1:0] OP_NABS = 3'd1;
  localparam logic [OP_W-1:0] OP_DOZ  = 3'd2;
  localparam logic [OP_W-1:0] OP_DOZI = 3'd3;
  localparam logic [OP_W-1:0] OP_CLCS = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

  localparam logic [DATA_W-1:0] SIGN_WORD  = 32'h8000_0000;
  localparam logic [DATA_W-1:0] CLCS_LOW   = 32'hBADB_AD00;
  localparam logic [DATA_W-1:0] CLCS_HIGH  = 32'h0BAD_BAD0;
  localparam logic [DATA_W-1:0] CLCS_MID   = 32'h00BA_DBAD;
  localparam logic [CLS_W-1:0]  CLS_MASK_GRP = 5'h18;
  localparam logic [CLS_W-1:0]  CLS_MASK_SUB = 5'h1C;
  localparam logic [CLS_W-1:0]  CLS_MID_VAL  = 5'h08;

  // LT, GT, EQ of a word against zero
  function automatic logic [2:0] sign_bits(input logic [DATA_W-1:0] value);
    logic [2:0] bits;
    if (value == '0) begin
      bits = 3'b001;
    end else if (value[DATA_W-1]) begin
      bits = 3'b100;
    end else begin
      bits = 3'b010;
    end
    return bits;
  endfunction

  // Cache class answer for one class code
  function automatic logic [DATA_W-1:0] clcs_value(input logic [CLS_W-1:0] cls,
                                                    input logic [LINE_W-1:0] line);
    logic [DATA_W-1:0] value;
    if ((cls & CLS_MASK_GRP) == '0) begin
      value = CLCS_LOW;
    end else if (cls[CLS_W-1]) begin
      value = CLCS_HIGH;
    end else if ((cls & CLS_MASK_SUB) == CLS_MID_VAL) begin
      value = CLCS_MID;
    end else begin
      value = {{(DATA_W-LINE_W){1'b0}}, line};
    end
    return value;
  endfunction

endpackage

>>> design/power_legacy_alu_unit.sv
// Legacy POWER integer unit: abs, nabs, doz, dozi, clcs and div.
// Depends on pla_pkg.
//
// Usage:
//   in_*  : one instruction request per valid/ready handshake. in_ready is
//           high only while the unit is idle; one instruction is worked on
//           at a time.
//   out_* : one result request per instruction, held in an output register
//           until out_ready takes it. The next instruction may be accepted
//           while that result still waits.
//   cfg_* : write of the cache line size returned by clcs; always ready.
// Sequence:
//   abs, nabs, doz, dozi, clcs: worked in S_EXEC, then S_DONE.
//   div: dividend magnitude (S_DLO, S_DHI), divisor magnitude (S_BMAG),
//   overflow check (S_CHK), 32 restoring steps through the single shared
//   33-bit subtractor (S_DIV), then sign fix-up steps (S_QFIX, S_RFIX);
//   an overflow check that trips in S_CHK or S_QFIX goes to S_DONE.
//   Results commit to MQ/OV/SO only when the output register is free, so a
//   stalled receiver holds the finished instruction in its last step.
// Reset: synchronous, active low; clears MQ, OV, SO, the output valid and
//   sets the cache line size to 64.
module power_legacy_alu_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // instruction requests
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [pla_pkg::OP_W-1:0]      in_op,
  input  logic signed [pla_pkg::DATA_W-1:0] in_a_value,
  input  logic signed [pla_pkg::DATA_W-1:0] in_b_value,
  input  logic [pla_pkg::CLS_W-1:0]     in_class_code,
  input  logic                          in_record_cr,
  input  logic                          in_record_ov,
  // result requests
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pla_pkg::DATA_W-1:0]    out_result,
  output logic [pla_pkg::CR_W-1:0]      out_cr0,
  output logic                          out_cr0_written,
  output logic                          out_overflow,
  output logic                          out_summary_overflow,
  output logic [pla_pkg::DATA_W-1:0]    out_mq_value,
  // configuration write
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pla_pkg::LINE_W-1:0]    cfg_cache_line_bytes
);
  import pla_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DLO, S_DHI, S_BMAG, S_CHK, S_DIV, S_QFIX, S_RFIX, S_DONE
  } state_t;

  localparam logic [LINE_W-1:0] LINE_RESET = 11'd64;
  localparam logic [CNT_W-1:0]  CNT_LAST   = CNT_W'(DATA_W - 1);
  localparam logic [CNT_W-1:0]  CNT_ONE    = CNT_W'(1);

  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [DATA_W-1:0]   a_r, a_nxt;
  logic [DATA_W-1:0]   b_r, b_nxt;
  logic [CLS_W-1:0]    cls_r, cls_nxt;
  logic                rc_r, rc_nxt;
  logic                oe_r, oe_nxt;
  logic [DATA_W-1:0]   rem_r, rem_nxt;
  logic [DATA_W-1:0]   quo_r, quo_nxt;
  logic [DATA_W-1:0]   bmag_r, bmag_nxt;
  logic                brw_r, brw_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DATA_W-1:0]   res_r, res_nxt;
  logic                ovf_r, ovf_nxt;
  logic                dovf_r, dovf_nxt;
  logic [DATA_W-1:0]   mqw_r, mqw_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_result_r, out_result_nxt;
  logic [CR_W-1:0]     out_cr0_r, out_cr0_nxt;
  logic                out_crw_r, out_crw_nxt;
  logic [DATA_W-1:0]   mq_r, mq_nxt;
  logic                ov_r, ov_nxt;
  logic                so_r, so_nxt;
  logic [LINE_W-1:0]   line_r, line_nxt;

  // shared subtractor: x - y - bin, top bit is the borrow out
  logic [DATA_W:0]     alu_x, alu_y;
  logic                alu_bin;
  logic [DATA_W+1:0]   alu_d;
  logic                alu_borrow;

  logic                in_acc;
  logic                commit;
  logic                apply;
  logic                qneg;
  logic                qbig;
  logic                lt;

  assign in_ready   = (state_r == S_IDLE);
  assign in_acc     = in_valid & in_ready;
  assign cfg_ready  = 1'b1;
  assign alu_d      = {1'b0, alu_x} - {1'b0, alu_y} - {{(DATA_W+1){1'b0}}, alu_bin};
  assign alu_borrow = alu_d[DATA_W+1];
  assign qneg       = a_r[DATA_W-1] ^ b_r[DATA_W-1];
  assign qbig       = qneg ? (quo_r[DATA_W-1] & (|quo_r[DATA_W-2:0])) : quo_r[DATA_W-1];
  assign lt         = !alu_d[DATA_W] && (alu_d[DATA_W:0] != '0);
  assign apply      = op_r inside {OP_ABS, OP_NABS, OP_DOZ, OP_DIV};

  // Select the subtractor operands for the current step
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_bin = 1'b0;
    case (state_r)
      S_EXEC: begin
        if (op_r == OP_DOZ || op_r == OP_DOZI) begin
          alu_x = {b_r[DATA_W-1], b_r};
          alu_y = {a_r[DATA_W-1], a_r};
        end else begin
          alu_y = {1'b0, a_r};
        end
      end
      S_DLO:  alu_y = {1'b0, mq_r};
      S_DHI: begin
        alu_y   = {1'b0, a_r};
        alu_bin = brw_r;
      end
      S_BMAG: alu_y = {1'b0, b_r};
      S_CHK: begin
        alu_x = {1'b0, rem_r};
        alu_y = {1'b0, bmag_r};
      end
      S_DIV: begin
        alu_x = {rem_r, quo_r[DATA_W-1]};
        alu_y = {1'b0, bmag_r};
      end
      S_QFIX: alu_y = {1'b0, quo_r};
      S_RFIX: alu_y = {1'b0, rem_r};
      default: begin
        alu_x = '0;
      end
    endcase
  end

  // Sequencer and commit logic
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    cls_nxt        = cls_r;
    rc_nxt         = rc_r;
    oe_nxt         = oe_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    bmag_nxt       = bmag_r;
    brw_nxt        = brw_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    ovf_nxt        = ovf_r;
    dovf_nxt       = dovf_r;
    mqw_nxt        = mqw_r;
    out_result_nxt = out_result_r;
    out_cr0_nxt    = out_cr0_r;
    out_crw_nxt    = out_crw_r;
    mq_nxt         = mq_r;
    ov_nxt         = ov_r;
    so_nxt         = so_r;
    line_nxt       = cfg_valid ? cfg_cache_line_bytes : line_r;
    commit         = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_op;
          a_nxt     = $unsigned(in_a_value);
          b_nxt     = $unsigned(in_b_value);
          cls_nxt   = in_class_code;
          rc_nxt    = in_record_cr;
          oe_nxt    = in_record_ov;
          dovf_nxt  = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = (in_op == OP_DIV) ? S_DLO : S_EXEC;
        end
      end
      // single-step operations
      S_EXEC: begin
        ovf_nxt = 1'b0;
        case (op_r)
          OP_ABS: begin
            res_nxt = a_r[DATA_W-1] ? alu_d[DATA_W-1:0] : a_r;
            ovf_nxt = (a_r == SIGN_WORD);
          end
          OP_NABS: res_nxt = a_r[DATA_W-1] ? a_r : alu_d[DATA_W-1:0];
          OP_DOZ, OP_DOZI: begin
            res_nxt = lt ? alu_d[DATA_W-1:0] : '0;
            ovf_nxt = lt & alu_d[DATA_W-1];
          end
          OP_CLCS: res_nxt = clcs_value(cls_r, line_r);
          default: res_nxt = '0;
        endcase
        state_nxt = S_DONE;
      end
      // dividend magnitude, low word then high word with borrow
      S_DLO: begin
        quo_nxt   = a_r[DATA_W-1] ? alu_d[DATA_W-1:0] : mq_r;
        brw_nxt   = a_r[DATA_W-1] & (mq_r != '0);
        state_nxt = S_DHI;
      end
      S_DHI: begin
        rem_nxt   = a_r[DATA_W-1] ? alu_d[DATA_W-1:0] : a_r;
        state_nxt = S_BMAG;
      end
      S_BMAG: begin
        bmag_nxt  = b_r[DATA_W-1] ? alu_d[DATA_W-1:0] : b_r;
        state_nxt = S_CHK;
      end
      // high word not below divisor: quotient needs more than one word
      S_CHK: begin
        cnt_nxt = '0;
        if (!alu_borrow) begin
          res_nxt   = SIGN_WORD;
          mqw_nxt   = '0;
          ovf_nxt   = 1'b1;
          dovf_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      // one restoring quotient bit per cycle
      S_DIV: begin
        rem_nxt = alu_borrow ? {rem_r[DATA_W-2:0], quo_r[DATA_W-1]} : alu_d[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], !alu_borrow};
        cnt_nxt = cnt_r + CNT_ONE;
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_QFIX;
        end
      end
      S_QFIX: begin
        if (qbig) begin
          res_nxt   = SIGN_WORD;
          mqw_nxt   = '0;
          ovf_nxt   = 1'b1;
          dovf_nxt  = 1'b1;
          state_nxt = S_DONE;
        end else begin
          res_nxt   = qneg ? alu_d[DATA_W-1:0] : quo_r;
          state_nxt = S_RFIX;
        end
      end
      S_RFIX: begin
        mqw_nxt   = a_r[DATA_W-1] ? alu_d[DATA_W-1:0] : rem_r;
        state_nxt = S_DONE;
      end
      // commit architectural state and load the output register
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          commit         = 1'b1;
          ov_nxt         = (apply & oe_r) ? ovf_r : ov_r;
          so_nxt         = so_r | (apply & oe_r & ovf_r);
          mq_nxt         = (op_r == OP_DIV) ? mqw_r : mq_r;
          out_result_nxt = res_r;
          out_crw_nxt    = apply & rc_r;
          out_cr0_nxt    = (apply & rc_r) ?
                           {(dovf_r ? 3'b000 : sign_bits(res_r)), so_nxt} : '0;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = commit | (out_valid_r & !out_ready);
  end

  // Hold state, work registers and the output register
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    cls_r        <= cls_nxt;
    rc_r         <= rc_nxt;
    oe_r         <= oe_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    bmag_r       <= bmag_nxt;
    brw_r        <= brw_nxt;
    res_r        <= res_nxt;
    ovf_r        <= ovf_nxt;
    dovf_r       <= dovf_nxt;
    mqw_r        <= mqw_nxt;
    out_result_r <= out_result_nxt;
    out_cr0_r    <= out_cr0_nxt;
    out_crw_r    <= out_crw_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      mq_r        <= '0;
      ov_r        <= 1'b0;
      so_r        <= 1'b0;
      line_r      <= LINE_RESET;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      mq_r        <= mq_nxt;
      ov_r        <= ov_nxt;
      so_r        <= so_nxt;
      line_r      <= line_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_result           = out_result_r;
  assign out_cr0              = out_cr0_r;
  assign out_cr0_written      = out_crw_r;
  assign out_overflow         = ov_r;
  assign out_summary_overflow = so_r;
  assign out_mq_value         = mq_r;

endmodule

>>> design/pla_checker.sv
// Port-level checker for the legacy POWER integer unit, bound to the top.
// Depends on power_legacy_alu_unit_macros.svh.
`include "power_legacy_alu_unit_macros.svh"

module pla_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result,
  input logic [3:0]  out_cr0,
  input logic        out_cr0_written,
  input logic        out_summary_overflow
);

  // one instruction at a time: busy right after an accept
  `PLA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  // a stalled result holds
  `PLA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_result))
  // SO is sticky
  `PLA_ASSERT_IMP(a_so_sticky, 1'b1, !$fell(out_summary_overflow))
  // untouched CR0 reads as zero
  `PLA_ASSERT_IMP(a_cr0_clear, out_valid && !out_cr0_written, out_cr0 == 4'b0000)
  // CR0 carries the SO copy
  `PLA_ASSERT_IMP(a_cr0_so, out_valid && out_cr0_written, out_cr0[0] == out_summary_overflow)

endmodule

bind power_legacy_alu_unit pla_checker u_pla_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_result           (out_result),
  .out_cr0              (out_cr0),
  .out_cr0_written      (out_cr0_written),
  .out_summary_overflow (out_summary_overflow)
);
